// ===== rtl/pie_pkg.sv =====
package pie_pkg;

   // Default largest matrix dimension.
   localparam int N_MAX_DEF = 64;

   // Fixed field widths.
   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int SIZE_W      = 7;
   localparam int TOL_W       = 25;
   localparam int PASS_W      = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int WIDE_W      = 64;

   // Unity in Q8.24.
   localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sh0100_0000;

   // Register reset values.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd2;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 25'd17;
   localparam logic [PASS_W-1:0] PASS_RESET = 10'd1000;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PASSES  = 2'd2;

   // Divider: a 64-bit magnitude followed by 24 fraction bits.
   localparam int DIV_FRAC_BITS = 24;
   localparam int DIV_STEPS     = WIDE_W + DIV_FRAC_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

endpackage

// ===== rtl/power_iteration_eigen.sv =====
// Dominant eigenvalue of a square matrix by power iteration, signed Q8.24.
//
// Items enter on the req_ channel. An item with kind 0 writes one matrix
// element into the matrix memory and yields no result. An item with kind 1
// starts a run from the all-ones vector; req_stall stays high until every
// result of the run has been taken. A run yields matrix_size result items
// (size 0 counts as 1, sizes above N_MAX as N_MAX) on the rsp_ channel, one
// per vector element, with the last flag on the final one. A result is shown until
// rsp_stall is low; a stalled receiver only holds the block, nothing is lost.
//
// Steps of a run: the vector is seeded, then each pass runs the two
// matrix-vector products (one multiply a cycle through the matrix memory), the
// dot products, the square root, the normalizing divisions and the Rayleigh
// division and convergence check (one quotient bit a cycle in the shared
// divider) and the vector copy. Each result is read from the current vector
// memory and then shown.
//
// Reset clears the sequencer and loads the registers with size 2, tolerance 17 and pass
// limit 1000. The memories are not cleared; the matrix must be loaded before a run. The
// user must write registers on the csr_ channel only while idle, unenforced by the block.
module power_iteration_eigen #(
   parameter int N_MAX = pie_pkg::N_MAX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [pie_pkg::INDEX_W-1:0]            req_row_index,
   input  logic [pie_pkg::INDEX_W-1:0]            req_col_index,
   input  logic signed [pie_pkg::DATA_W-1:0]      req_element_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pie_pkg::DATA_W-1:0]      rsp_eigenvalue,
   output logic [pie_pkg::INDEX_W-1:0]            rsp_vector_index,
   output logic signed [pie_pkg::DATA_W-1:0]      rsp_vector_element,
   output logic                                   rsp_converged,
   output logic                                   rsp_zero_norm,
   output logic [pie_pkg::PASS_W-1:0]             rsp_passes_used,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pie_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pie_pkg::TOL_W-1:0]              csr_data
);
   import pie_pkg::*;

   localparam int IDX_W = $clog2(N_MAX);
   localparam int CNT_W = $clog2(N_MAX + 1);
   localparam int MAT_W = $clog2(N_MAX * N_MAX);

   // One-hot sequencer states.
   typedef enum logic [16:0] {
      S_IDLE     = 17'b1 << 0,
      S_INIT     = 17'b1 << 1,
      S_MV1      = 17'b1 << 2,
      S_SS1      = 17'b1 << 3,
      S_SQRT     = 17'b1 << 4,
      S_NORM_RD  = 17'b1 << 5,
      S_NORM_LD  = 17'b1 << 6,
      S_NORM_DIV = 17'b1 << 7,
      S_MV2      = 17'b1 << 8,
      S_DOT      = 17'b1 << 9,
      S_SS2      = 17'b1 << 10,
      S_DIV_LD   = 17'b1 << 11,
      S_DIV_WAIT = 17'b1 << 12,
      S_CHECK    = 17'b1 << 13,
      S_COPY     = 17'b1 << 14,
      S_OUT_RD   = 17'b1 << 15,
      S_OUT_SHOW = 17'b1 << 16
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   state_type                  state_ff, state_in;
   logic [SIZE_W-1:0]          size_ff, size_in;
   logic [TOL_W-1:0]           tol_ff, tol_in;
   logic [PASS_W-1:0]          maxp_ff, maxp_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [CNT_W-1:0]           col_ff, col_in;
   logic [CNT_W-1:0]           row_ff, row_in;
   logic                       v1_ff, v1_in;
   logic                       v2_ff, v2_in;
   logic [IDX_W-1:0]           d1_ff, d1_in;
   logic signed [WIDE_W-1:0]   mul_ff, mul_in;
   logic signed [WIDE_W-1:0]   acc_ff, acc_in;
   logic [WIDE_W-1:0]          sq_v_ff, sq_v_in;
   logic [WIDE_W-1:0]          sq_res_ff, sq_res_in;
   logic [WIDE_W-1:0]          sq_bit_ff, sq_bit_in;
   logic [4:0]                 sq_cnt_ff, sq_cnt_in;
   logic signed [WIDE_W-1:0]   num_ff, num_in;
   logic [WIDE_W-1:0]          den_ff, den_in;
   logic signed [DATA_W-1:0]   eig_ff, eig_in;
   logic signed [DATA_W-1:0]   prev_ff, prev_in;
   logic [PASS_W-1:0]          pass_ff, pass_in;
   logic                       conv_ff, conv_in;
   logic                       zn_ff, zn_in;

   // Memory ports.
   logic                       mat_we, mat_re;
   logic [MAT_W-1:0]           mat_waddr, mat_raddr;
   logic [DATA_W-1:0]          mat_rdata;
   logic                       cur_we, cur_re;
   logic [IDX_W-1:0]           cur_waddr;
   logic [DATA_W-1:0]          cur_wdata, cur_rdata;
   logic                       nxt_we, nxt_re;
   logic [DATA_W-1:0]          nxt_wdata, nxt_rdata;
   logic                       prd_we, prd_re;
   logic [IDX_W-1:0]           prd_waddr;
   logic [DATA_W-1:0]          prd_wdata, prd_rdata;

   // Divider.
   logic                       div_start, div_neg, div_done;
   logic [WIDE_W-1:0]          div_mag, div_den;
   logic signed [DATA_W-1:0]   div_quo;

   logic                       req_accept;
   logic [CNT_W-1:0]           col_inc, row_inc;
   logic [IDX_W-1:0]           col_idx;
   logic                       issue, drained, square_mode;
   logic signed [DATA_W-1:0]   op_a, op_b;
   logic signed [WIDE_W:0]     sum_s;
   logic [WIDE_W:0]            sum_u;
   logic [WIDE_W-1:0]          sq_try;
   logic signed [WIDE_W-1:0]   prd_ext;
   logic signed [DATA_W:0]     diff;
   logic [DATA_W:0]            diff_abs;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign col_inc = col_ff + CNT_W'(1);
   assign row_inc = row_ff + CNT_W'(1);
   assign col_idx = col_ff[IDX_W-1:0];

   // Loads go straight into the matrix memory.
   assign mat_we    = req_accept & ~req_kind
                      & (int'(req_row_index) < N_MAX) & (int'(req_col_index) < N_MAX);
   assign mat_waddr = MAT_W'(req_row_index) * MAT_W'(N_MAX) + MAT_W'(req_col_index);
   assign mat_raddr = MAT_W'(row_ff) * MAT_W'(N_MAX) + MAT_W'(col_ff);

   // Register writes.
   always_comb begin
      size_in = size_ff;
      tol_in  = tol_ff;
      maxp_in = maxp_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: size_in = csr_data[SIZE_W-1:0];
            CSR_TOLERANCE:   tol_in  = csr_data;
            CSR_MAX_PASSES:  maxp_in = csr_data[PASS_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiply-accumulate stream.
   always_comb begin
      op_a        = $signed(prd_rdata);
      op_b        = $signed(prd_rdata);
      square_mode = 1'b0;
      unique case (state_ff)
         S_MV1: begin
            op_a = $signed(mat_rdata);
            op_b = $signed(cur_rdata);
         end
         S_MV2: begin
            op_a = $signed(mat_rdata);
            op_b = $signed(nxt_rdata);
         end
         S_DOT: begin
            op_b = $signed(nxt_rdata);
         end
         S_SS1: begin
            square_mode = 1'b1;
         end
         S_SS2: begin
            op_a        = $signed(nxt_rdata);
            op_b        = $signed(nxt_rdata);
            square_mode = 1'b1;
         end
         default: ;
      endcase
   end

   assign mul_in   = op_a * op_b;
   assign sum_s    = {acc_ff[WIDE_W-1], acc_ff} + {mul_ff[WIDE_W-1], mul_ff};
   assign sum_u    = {1'b0, acc_ff} + {1'b0, mul_ff};
   assign sq_try   = sq_res_ff + sq_bit_ff;
   assign prd_ext  = WIDE_W'($signed(prd_rdata));
   assign diff     = {eig_ff[DATA_W-1], eig_ff} - {prev_ff[DATA_W-1], prev_ff};
   assign diff_abs = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;
   assign issue    = col_ff != n_ff;
   assign drained  = ~issue & ~v1_ff & ~v2_ff;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      v1_in     = 1'b0;
      v2_in     = 1'b0;
      d1_in     = col_idx;
      acc_in    = acc_ff;
      sq_v_in   = sq_v_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      sq_cnt_in = sq_cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      eig_in    = eig_ff;
      prev_in   = prev_ff;
      pass_in   = pass_ff;
      conv_in   = conv_ff;
      zn_in     = zn_ff;

      mat_re    = 1'b0;
      cur_we    = 1'b0;
      cur_re    = 1'b0;
      cur_waddr = col_idx;
      cur_wdata = ONE_Q24;
      nxt_we    = 1'b0;
      nxt_re    = 1'b0;
      nxt_wdata = div_quo;
      prd_we    = 1'b0;
      prd_re    = 1'b0;
      prd_waddr = row_ff[IDX_W-1:0];
      prd_wdata = sat32(acc_ff >>> DIV_FRAC_BITS);

      div_start = 1'b0;
      div_neg   = num_ff[WIDE_W-1];
      div_mag   = num_ff[WIDE_W-1] ? WIDE_W'(0) - num_ff : num_ff;
      div_den   = den_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_kind) begin
               if (size_ff == '0) begin
                  n_in = CNT_W'(1);
               end else if (int'(size_ff) > N_MAX) begin
                  n_in = CNT_W'(N_MAX);
               end else begin
                  n_in = CNT_W'(size_ff);
               end
               col_in   = '0;
               pass_in  = '0;
               prev_in  = '0;
               eig_in   = '0;
               conv_in  = 1'b0;
               zn_in    = 1'b0;
               state_in = S_INIT;
            end
         end

         S_INIT: begin
            cur_we = 1'b1;
            col_in = col_inc;
            if (col_inc == n_ff) begin
               col_in = '0;
               row_in = '0;
               acc_in = '0;
               state_in = (maxp_ff == '0) ? S_OUT_RD : S_MV1;
            end
         end

         S_MV1, S_MV2, S_SS1, S_DOT, S_SS2: begin
            // Issue one element a cycle; the memory registers the data, the
            // multiplier registers the product, then it is accumulated.
            if (issue) begin
               v1_in  = 1'b1;
               col_in = col_inc;
            end
            v2_in  = v1_ff;
            mat_re = issue & ((state_ff == S_MV1) | (state_ff == S_MV2));
            cur_re = issue & (state_ff == S_MV1);
            prd_re = issue & ((state_ff == S_SS1) | (state_ff == S_DOT));
            nxt_re = issue & ((state_ff == S_MV2) | (state_ff == S_DOT) | (state_ff == S_SS2));
            if (v2_ff) begin
               if (square_mode) begin
                  acc_in = sum_u[WIDE_W] ? {WIDE_W{1'b1}} : sum_u[WIDE_W-1:0];
               end else if (sum_s[WIDE_W] != sum_s[WIDE_W-1]) begin
                  acc_in = sum_s[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}}
                                         : {1'b0, {(WIDE_W-1){1'b1}}};
               end else begin
                  acc_in = sum_s[WIDE_W-1:0];
               end
            end
            if (drained) begin
               col_in = '0;
               acc_in = '0;
               unique case (state_ff)
                  S_MV1, S_MV2: begin
                     prd_we = 1'b1;
                     row_in = row_inc;
                     if (row_inc == n_ff) begin
                        row_in   = '0;
                        state_in = (state_ff == S_MV1) ? S_SS1 : S_DOT;
                     end
                  end
                  S_SS1: begin
                     sq_v_in   = acc_ff;
                     sq_res_in = '0;
                     sq_bit_in = {2'b01, {(WIDE_W-2){1'b0}}};
                     sq_cnt_in = 5'd31;
                     state_in  = S_SQRT;
                  end
                  S_DOT: begin
                     num_in   = acc_ff;
                     state_in = S_SS2;
                  end
                  default: begin
                     den_in   = acc_ff;
                     state_in = S_DIV_LD;
                  end
               endcase
            end
         end

         S_SQRT: begin
            // One result bit a cycle.
            if (sq_v_ff >= sq_try) begin
               sq_v_in   = sq_v_ff - sq_try;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == '0) begin
               col_in = '0;
               if (sq_res_in == '0) begin
                  zn_in    = 1'b1;
                  eig_in   = '0;
                  state_in = S_OUT_RD;
               end else begin
                  state_in = S_NORM_RD;
               end
            end
         end

         S_NORM_RD: begin
            prd_re   = 1'b1;
            state_in = S_NORM_LD;
         end

         S_NORM_LD: begin
            div_start = 1'b1;
            div_neg   = prd_rdata[DATA_W-1];
            div_mag   = prd_rdata[DATA_W-1] ? WIDE_W'(0) - prd_ext : prd_ext;
            div_den   = {{(WIDE_W-DATA_W){1'b0}}, sq_res_ff[DATA_W-1:0]};
            state_in  = S_NORM_DIV;
         end

         S_NORM_DIV: begin
            if (div_done) begin
               nxt_we = 1'b1;
               col_in = col_inc;
               if (col_inc == n_ff) begin
                  col_in   = '0;
                  row_in   = '0;
                  acc_in   = '0;
                  state_in = S_MV2;
               end else begin
                  state_in = S_NORM_RD;
               end
            end
         end

         S_DIV_LD: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               eig_in   = div_quo;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            col_in = '0;
            if (diff_abs < {{(DATA_W+1-TOL_W){1'b0}}, tol_ff}) begin
               conv_in  = 1'b1;
               state_in = S_OUT_RD;
            end else begin
               prev_in  = eig_ff;
               pass_in  = pass_ff + PASS_W'(1);
               state_in = S_COPY;
            end
         end

         S_COPY: begin
            // The new iterate becomes the current one.
            if (issue) begin
               v1_in  = 1'b1;
               col_in = col_inc;
            end
            nxt_re    = issue;
            cur_we    = v1_ff;
            cur_waddr = d1_ff;
            cur_wdata = nxt_rdata;
            if (drained) begin
               col_in = '0;
               row_in = '0;
               acc_in = '0;
               state_in = (pass_ff < maxp_ff) ? S_MV1 : S_OUT_RD;
            end
         end

         S_OUT_RD: begin
            cur_re   = 1'b1;
            state_in = S_OUT_SHOW;
         end

         S_OUT_SHOW: begin
            if (!rsp_stall) begin
               col_in   = col_inc;
               state_in = (col_inc == n_ff) ? S_IDLE : S_OUT_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= SIZE_RESET;
         tol_ff   <= TOL_RESET;
         maxp_ff  <= PASS_RESET;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         prev_ff  <= '0;
         pass_ff  <= '0;
         conv_ff  <= 1'b0;
         zn_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         tol_ff   <= tol_in;
         maxp_ff  <= maxp_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         prev_ff  <= prev_in;
         pass_ff  <= pass_in;
         conv_ff  <= conv_in;
         zn_ff    <= zn_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      d1_ff     <= d1_in;
      mul_ff    <= mul_in;
      acc_ff    <= acc_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      eig_ff    <= eig_in;
   end

   pie_ram #(.WIDTH(DATA_W), .DEPTH(N_MAX * N_MAX)) u_matrix (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (req_element_value),
      .re    (mat_re),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   pie_ram #(.WIDTH(DATA_W), .DEPTH(N_MAX)) u_current (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .re    (cur_re),
      .raddr (col_idx),
      .rdata (cur_rdata)
   );

   pie_ram #(.WIDTH(DATA_W), .DEPTH(N_MAX)) u_next (
      .clock (clock),
      .we    (nxt_we),
      .waddr (col_idx),
      .wdata (nxt_wdata),
      .re    (nxt_re),
      .raddr (col_idx),
      .rdata (nxt_rdata)
   );

   pie_ram #(.WIDTH(DATA_W), .DEPTH(N_MAX)) u_product (
      .clock (clock),
      .we    (prd_we),
      .waddr (prd_waddr),
      .wdata (prd_wdata),
      .re    (prd_re),
      .raddr (col_idx),
      .rdata (prd_rdata)
   );

   pie_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .neg   (div_neg),
      .mag   (div_mag),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Results: the current vector memory holds its read data while shown.
   assign rsp_valid          = state_ff == S_OUT_SHOW;
   assign rsp_eigenvalue     = eig_ff;
   assign rsp_vector_index   = INDEX_W'(col_ff);
   assign rsp_vector_element = $signed(cur_rdata);
   assign rsp_converged      = conv_ff;
   assign rsp_zero_norm      = zn_ff;
   assign rsp_passes_used    = pass_ff;
   assign rsp_last           = col_inc == n_ff;

endmodule

// ===== rtl/pie_ram.sv =====
module pie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pie_div.sv =====
module pie_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               neg,
   input  logic [pie_pkg::WIDE_W-1:0]         mag,
   input  logic [pie_pkg::WIDE_W-1:0]         den,
   output logic                               done,
   output logic signed [pie_pkg::DATA_W-1:0]  quo
);
   import pie_pkg::*;

   // Restoring division of mag * 2^24 by den, one quotient bit a cycle.
   // Only 31 quotient bits are kept; anything above sets the overflow flag.
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [DIV_CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0]         dvd_ff, dvd_in;
   logic [WIDE_W-1:0]            rem_ff, rem_in;
   logic [WIDE_W-1:0]            den_ff, den_in;
   logic [DATA_W-2:0]            q_ff, q_in;
   logic                         ovf_ff, ovf_in;
   logic                         neg_ff, neg_in;
   logic signed [DATA_W-1:0]     quo_ff, quo_in;
   logic [WIDE_W:0]              rem_shift;
   logic [WIDE_W:0]              rem_diff;
   logic                         fits;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_shift = {rem_ff, dvd_ff[DIV_STEPS-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         dvd_in  = {mag, {DIV_FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = neg;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[WIDE_W-1:0] : rem_shift[WIDE_W-1:0];
         q_in   = {q_ff[DATA_W-3:0], fits};
         ovf_in = ovf_ff | q_ff[DATA_W-2];
         dvd_in = {dvd_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (den_ff == '0) begin
               quo_in = '0;
            end else if (ovf_in) begin
               quo_in = neg_ff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            end else if (neg_ff) begin
               quo_in = -$signed({1'b0, q_in});
            end else begin
               quo_in = $signed({1'b0, q_in});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== tb/power_iteration_eigen_test.sv =====
`timescale 1ns / 1ps

module power_iteration_eigen_test;
   import pie_pkg::*;

   localparam int  DIM           = N_MAX_DEF;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  LONG_HOLD     = 3000;
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_START   = 1'b1;
   // The index just past the register list; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [31:0] Q24_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q24_MIN = 32'sh8000_0000;
   localparam longint WIDE_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint WIDE_MIN = 64'sh8000_0000_0000_0000;

   // What sits in the stimulus queue: an item, a register write, or a pause
   // until every expected result has come back.
   typedef enum logic [1:0] {ENT_ITEM, ENT_CSR, ENT_DRAIN} entry_kind_type;

   typedef struct {
      entry_kind_type            what;
      logic                      kind;
      logic [INDEX_W-1:0]        row;
      logic [INDEX_W-1:0]        col;
      logic signed [DATA_W-1:0]  value;
      logic [CSR_INDEX_W-1:0]    index;
      logic [TOL_W-1:0]          data;
   } stim_type;

   typedef struct {
      logic signed [DATA_W-1:0]  eigenvalue;
      logic [INDEX_W-1:0]        vector_index;
      logic signed [DATA_W-1:0]  vector_element;
      logic                      converged;
      logic                      zero_norm;
      logic [PASS_W-1:0]         passes_used;
      logic                      last;
   } eigen_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = 1'b0;
   logic [INDEX_W-1:0]        req_row_index = '0;
   logic [INDEX_W-1:0]        req_col_index = '0;
   logic signed [DATA_W-1:0]  req_element_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]  rsp_eigenvalue;
   logic [INDEX_W-1:0]        rsp_vector_index;
   logic signed [DATA_W-1:0]  rsp_vector_element;
   logic                      rsp_converged;
   logic                      rsp_zero_norm;
   logic [PASS_W-1:0]         rsp_passes_used;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [TOL_W-1:0]          csr_data = '0;

   power_iteration_eigen u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_eigenvalue     (rsp_eigenvalue),
      .rsp_vector_index   (rsp_vector_index),
      .rsp_vector_element (rsp_vector_element),
      .rsp_converged      (rsp_converged),
      .rsp_zero_norm      (rsp_zero_norm),
      .rsp_passes_used    (rsp_passes_used),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // Stimulus waiting to be driven, and the results the eigen solver owes us.
   stim_type         pending_q[$];
   eigen_result_type eigen_results_q[$];
   int               fail_count = 0;
   int               results_taken = 0;

   // Acceptance seen at the last rising edge, read by the falling-edge driver.
   logic req_took = 1'b0;
   logic csr_took = 1'b0;

   // ------------------------------------------------------------------
   // Behavioral copy of the solver: registers, matrix and work vectors.
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0]         cfg_size   = SIZE_RESET;
   logic [TOL_W-1:0]          cfg_tol    = TOL_RESET;
   logic [PASS_W-1:0]         cfg_passes = PASS_RESET;
   logic signed [DATA_W-1:0]  model_matrix [DIM][DIM];
   logic signed [DATA_W-1:0]  iterate_vec [DIM];
   logic signed [DATA_W-1:0]  unit_vec [DIM];
   logic signed [DATA_W-1:0]  product_vec [DIM];

   function automatic longint add_sat64(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return a[63] ? WIDE_MIN : WIDE_MAX;
      return s;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(Q24_MAX)) return Q24_MAX;
      if (v < longint'(Q24_MIN)) return Q24_MIN;
      return v[31:0];
   endfunction

   function automatic logic [31:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [63:0] squares_sum(logic signed [31:0] v[DIM], int n);
      logic [63:0] s;
      logic [63:0] sq;
      s = '0;
      for (int i = 0; i < n; i++) begin
         sq = longint'(v[i]) * longint'(v[i]);
         s = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
      end
      return s;
   endfunction

   // num * 2^24 / den, truncated toward zero, with 32-bit saturation.
   function automatic logic signed [31:0] quotient_q24(longint num, logic [63:0] den);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] m;
      neg = num < 0;
      mag = neg ? 64'd0 - num : num;
      if (den == 0) return '0;
      q = mag / den;
      r = mag % den;
      if (q >= 256) return neg ? Q24_MIN : Q24_MAX;
      m = q;
      for (int k = 0; k < 24; k++) begin
         r = r << 1;
         m = m << 1;
         if (r >= den) begin
            r = r - den;
            m[0] = 1'b1;
         end
      end
      if (neg) return (m >= 64'h8000_0000) ? Q24_MIN : -m[31:0];
      return (m > 64'h7fff_ffff) ? Q24_MAX : m[31:0];
   endfunction

   // product_vec = matrix * v, floor-shifted back to Q8.24 and saturated.
   function automatic void multiply_matrix(logic signed [31:0] v[DIM], int n);
      longint acc;
      for (int i = 0; i < n; i++) begin
         acc = 0;
         for (int j = 0; j < n; j++)
            acc = add_sat64(acc, longint'(model_matrix[i][j]) * longint'(v[j]));
         product_vec[i] = clamp32(acc >>> 24);
      end
   endfunction

   // Runs power iteration with the current register values and queues one
   // expected result per element of the final iterate.
   function automatic void predict_eigen_run();
      int                   n;
      int                   passes;
      logic [31:0]          norm;
      longint               num;
      longint               diff;
      logic [63:0]          den;
      logic signed [31:0]   eig;
      logic signed [31:0]   prev_eig;
      logic                 conv;
      logic                 zn;
      eigen_result_type     r;
      n = (cfg_size == 0) ? 1 : (cfg_size > DIM) ? DIM : int'(cfg_size);
      for (int i = 0; i < n; i++) iterate_vec[i] = ONE_Q24;
      prev_eig = '0;
      eig = '0;
      passes = 0;
      conv = 1'b0;
      zn = 1'b0;
      while (passes < cfg_passes) begin
         multiply_matrix(iterate_vec, n);
         norm = root_floor(squares_sum(product_vec, n));
         if (norm == 0) begin
            zn = 1'b1;
            eig = '0;
            break;
         end
         for (int i = 0; i < n; i++)
            unit_vec[i] = clamp32((longint'(product_vec[i]) * longint'(ONE_Q24))
                                  / longint'({32'b0, norm}));
         multiply_matrix(unit_vec, n);
         num = 0;
         for (int i = 0; i < n; i++)
            num = add_sat64(num, longint'(product_vec[i]) * longint'(unit_vec[i]));
         den = squares_sum(unit_vec, n);
         eig = quotient_q24(num, den);
         diff = longint'(eig) - longint'(prev_eig);
         if (diff < 0) diff = -diff;
         if (diff < longint'({39'b0, cfg_tol})) begin
            conv = 1'b1;
            break;
         end
         for (int i = 0; i < n; i++) iterate_vec[i] = unit_vec[i];
         prev_eig = eig;
         passes++;
      end
      for (int i = 0; i < n; i++) begin
         r.eigenvalue     = eig;
         r.vector_index   = i[INDEX_W-1:0];
         r.vector_element = iterate_vec[i];
         r.converged      = conv;
         r.zero_norm      = zn;
         r.passes_used    = passes[PASS_W-1:0];
         r.last           = (i + 1 == n);
         eigen_results_q.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // Rising edge: record acceptances, update the model, check results.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      eigen_result_type exp_r;
      req_took <= !reset && req_valid && !req_stall;
      csr_took <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATRIX_SIZE: cfg_size   = csr_data[SIZE_W-1:0];
               CSR_TOLERANCE:   cfg_tol    = csr_data;
               CSR_MAX_PASSES:  cfg_passes = csr_data[PASS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_LOAD)
               model_matrix[req_row_index][req_col_index] = req_element_value;
            else
               predict_eigen_run();
         end
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            if (eigen_results_q.size() == 0) begin
               $error("result with no expectation: index %0d", rsp_vector_index);
               fail_count++;
            end else begin
               exp_r = eigen_results_q.pop_front();
               if (rsp_eigenvalue !== exp_r.eigenvalue) begin
                  $error("eigenvalue: expected %0d, got %0d", exp_r.eigenvalue,
                         rsp_eigenvalue);
                  fail_count++;
               end
               if (rsp_vector_index !== exp_r.vector_index) begin
                  $error("vector_index: expected %0d, got %0d", exp_r.vector_index,
                         rsp_vector_index);
                  fail_count++;
               end
               if (rsp_vector_element !== exp_r.vector_element) begin
                  $error("vector_element: expected %0d, got %0d",
                         exp_r.vector_element, rsp_vector_element);
                  fail_count++;
               end
               if (rsp_converged !== exp_r.converged) begin
                  $error("converged: expected %0d, got %0d", exp_r.converged,
                         rsp_converged);
                  fail_count++;
               end
               if (rsp_zero_norm !== exp_r.zero_norm) begin
                  $error("zero_norm: expected %0d, got %0d", exp_r.zero_norm,
                         rsp_zero_norm);
                  fail_count++;
               end
               if (rsp_passes_used !== exp_r.passes_used) begin
                  $error("passes_used: expected %0d, got %0d", exp_r.passes_used,
                         rsp_passes_used);
                  fail_count++;
               end
               if (rsp_last !== exp_r.last) begin
                  $error("last: expected %0d, got %0d", exp_r.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Falling edge: item and register driver. Items go out in bursts with
   // random gaps. A register write or a drain marker waits until every
   // expected result has come back and quiet_cycles reaches SETTLE_CYCLES,
   // since a load yields nothing but may still be in flight.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      stim_type head;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= (eigen_results_q.size() == 0 && !req_took) ? quiet_cycles + 1 : 0;
         if (csr_valid) begin
            if (csr_took) csr_valid <= 1'b0;
         end else if (req_valid && !req_took) begin
            // The block stalled this item; it stays on the port unchanged.
         end else if (pending_q.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            head = pending_q[0];
            if (head.what != ENT_ITEM) begin
               req_valid <= 1'b0;
               if (eigen_results_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                  void'(pending_q.pop_front());
                  if (head.what == ENT_CSR) begin
                     csr_valid <= 1'b1;
                     csr_index <= head.index;
                     csr_data  <= head.data;
                  end
               end
            end else if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else begin
               void'(pending_q.pop_front());
               req_valid         <= 1'b1;
               req_kind          <= head.kind;
               req_row_index     <= head.row;
               req_col_index     <= head.col;
               req_element_value <= head.value;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Falling edge: result receiver. The stall pattern changes each time
   // the pattern counter wraps, and once, after 30 results and while an
   // item is being held off, the receiver holds its stall until the
   // LONG_HOLD counter runs out, so that the block backs up onto its input.
   // ------------------------------------------------------------------
   logic [5:0] pattern_cycle = '0;
   int         stall_mode = 0;
   int         hold_left = 0;
   logic       long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         pattern_cycle <= pattern_cycle + 1'b1;
         if (pattern_cycle == 6'd63) stall_mode <= $urandom_range(0, 3);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!long_hold_done && results_taken >= 30 && rsp_valid && req_valid) begin
            rsp_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus generation. The generator keeps its own view of the size
   // register and of which matrix elements have been written, so that a
   // start never makes the block read an element nobody loaded.
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0] plan_size = SIZE_RESET;
   bit                plan_written [DIM][DIM];

   function automatic logic signed [31:0] pick_element();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      if (sel < 7) return $urandom;
      if (sel < 9) return $urandom_range(0, 32'h0300_0000);
      case ($urandom_range(0, 2))
         0: return Q24_MAX;
         1: return Q24_MIN;
         default: return '0;
      endcase
   endfunction

   task automatic push_load(int r, int c, logic signed [31:0] v);
      stim_type s;
      s = '{what: ENT_ITEM, kind: KIND_LOAD, row: r[INDEX_W-1:0], col: c[INDEX_W-1:0],
            value: v, index: '0, data: '0};
      plan_written[r][c] = 1'b1;
      pending_q.push_back(s);
   endtask

   task automatic push_csr(logic [CSR_INDEX_W-1:0] idx, logic [TOL_W-1:0] d);
      stim_type s;
      s = '{what: ENT_CSR, kind: KIND_LOAD, row: '0, col: '0, value: '0,
            index: idx, data: d};
      if (idx == CSR_MATRIX_SIZE) plan_size = d[SIZE_W-1:0];
      pending_q.push_back(s);
   endtask

   task automatic push_drain();
      stim_type s;
      s = '{what: ENT_DRAIN, kind: KIND_LOAD, row: '0, col: '0, value: '0,
            index: '0, data: '0};
      pending_q.push_back(s);
   endtask

   // Loads whatever part of the active matrix is still unwritten, then
   // issues the start item itself with random payload in the unused fields.
   task automatic push_start();
      stim_type s;
      int       n;
      n = (plan_size == 0) ? 1 : (plan_size > DIM) ? DIM : int'(plan_size);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (!plan_written[r][c]) push_load(r, c, pick_element());
      s = '{what: ENT_ITEM, kind: KIND_START, row: INDEX_W'($urandom),
            col: INDEX_W'($urandom), value: $urandom, index: '0, data: '0};
      pending_q.push_back(s);
   endtask

   initial begin
      int n;
      int sel;
      int steps;

      // Directed part. With the reset registers, a symmetric 2x2 matrix
      // whose dominant eigenvalue is 3.0 should converge.
      push_load(0, 0, 32'sh0200_0000);
      push_load(0, 1, ONE_Q24);
      push_load(1, 0, ONE_Q24);
      push_load(1, 1, 32'sh0200_0000);
      push_start();

      // A 1x1 matrix at both extremes, then zero to hit the zero-norm stop.
      push_csr(CSR_MATRIX_SIZE, 25'd1);
      push_load(0, 0, Q24_MAX);
      push_start();
      push_load(0, 0, Q24_MIN);
      push_start();
      push_load(0, 0, '0);
      push_start();

      // Loads at the far corners of the store, which must not disturb a
      // small matrix, and a write to the index past the register list.
      push_load(63, 63, $urandom);
      push_load(63, 0, $urandom);
      push_load(0, 63, $urandom);
      push_csr(CSR_UNUSED, '1);
      push_load(0, 0, 32'sh0180_0000);

      // No pass at all: eigenvalue 0 and the all-ones vector.
      push_csr(CSR_MAX_PASSES, 25'd0);
      push_start();

      // Size zero behaves as one; tolerance at zero never converges.
      push_csr(CSR_MATRIX_SIZE, 25'd0);
      push_csr(CSR_TOLERANCE, 25'd0);
      push_csr(CSR_MAX_PASSES, 25'd5);
      push_start();
      push_csr(CSR_TOLERANCE, 25'h100_0000);
      push_start();

      // A 3x3 matrix with a modest pass limit.
      push_csr(CSR_MAX_PASSES, 25'h3ff);
      push_csr(CSR_MATRIX_SIZE, 25'd3);
      push_csr(CSR_TOLERANCE, 25'd17);
      push_csr(CSR_MAX_PASSES, 25'd10);
      push_start();

      // Random phases: a register setting, then a mix of loads and starts.
      for (int phase = 0; phase < 14; phase++) begin
         sel = $urandom_range(0, 9);
         n = (sel < 7) ? $urandom_range(1, 4) : (sel < 9) ? $urandom_range(5, 8)
             : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 12));
         // Junk above the size field must be dropped by the block.
         push_csr(CSR_MATRIX_SIZE, ($urandom_range(0, 3) == 0)
                  ? TOL_W'({$urandom, 7'(n)}) : TOL_W'(n));
         case ($urandom_range(0, 3))
            0: push_csr(CSR_TOLERANCE, 25'd0);
            1: push_csr(CSR_TOLERANCE, TOL_W'($urandom_range(1, 4096)));
            2: push_csr(CSR_TOLERANCE, TOL_W'($urandom));
            default: push_csr(CSR_TOLERANCE, 25'h100_0000);
         endcase
         sel = $urandom_range(0, 19);
         push_csr(CSR_MAX_PASSES, (sel < 17) ? TOL_W'($urandom_range(1, 12))
                  : (sel < 19) ? 25'd0 : TOL_W'($urandom_range(13, 40)));
         if ($urandom_range(0, 5) == 0) push_csr(CSR_UNUSED, TOL_W'($urandom));
         steps = $urandom_range(8, 16);
         n = (plan_size == 0) ? 1 : (plan_size > DIM) ? DIM : int'(plan_size);
         for (int k = 0; k < steps; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               push_start();
            end else if ($urandom_range(0, 9) < 7) begin
               push_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         pick_element());
            end else begin
               push_load($urandom_range(0, 63), $urandom_range(0, 63), pick_element());
            end
            // Once midway the sender waits for everything to drain.
            if (phase == 7 && k == 3) push_drain();
         end
         push_start();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || csr_valid ||
             eigen_results_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (fail_count == 0 && eigen_results_q.size() == 0 && !rsp_valid) begin
         $display("[power_iteration_eigen] OK");
      end else begin
         $display("[power_iteration_eigen] ERROR");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #400_000_000;
      $display("[power_iteration_eigen] ERROR");
      $finish;
   end

endmodule
